// ===== rtl/core/swmf_pkg.sv =====
package swmf_pkg;

    // width of the window size write data
    localparam int CFG_W = 6;

    // per-cycle command shared by every cell of the sorted row
    typedef struct packed {
        logic clear;  // empty the row
        logic del;    // drop the oldest sample and close the gap
        logic ins;    // insert the new sample at its sorted place
    } t_cell_cmd;

endpackage

// ===== rtl/core/sliding_window_median_filter_unit.sv =====
// o_valid rises after the input transfer once the delete, insert and select steps are done;
// select waits while the output register holds an unread result. A new sample is taken only
// when the sequencer is idle, while a finished result may still wait in the output register
// the samples sit sorted in a row of cells; each step acts on the whole row at once
// reset (synchronous, active low): window size 1, window empty, output register empty
module sliding_window_median_filter_unit #(
    parameter int MAX_WINDOW   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH:0]   o_median_x2,
    output logic                           o_window_full,
    input  logic                           i_cfg_we,
    input  logic [swmf_pkg::CFG_W-1:0]     i_cfg_data
);
    import swmf_pkg::*;

    localparam int FW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_INS,
        S_MED
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [FW-1:0]                  r_win;
    logic [FW-1:0]                  n_win;
    logic [FW-1:0]                  r_fill;
    logic [FW-1:0]                  n_fill;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic signed [SAMPLE_WIDTH:0]   r_median_x2;
    logic signed [SAMPLE_WIDTH:0]   n_median_x2;
    logic                           r_window_full;
    logic                           n_window_full;

    t_cell_cmd                      w_cmd;
    logic [31:0]                    w_cfg_ext;
    logic                           w_full;
    logic [AW-1:0]                  w_rem_age;
    logic signed [SAMPLE_WIDTH-1:0] w_rem_value;
    logic [FW-1:0]                  w_lo_full;
    logic [FW-1:0]                  w_hi_full;
    logic signed [SAMPLE_WIDTH-1:0] w_lo;
    logic signed [SAMPLE_WIDTH-1:0] w_hi;
    logic                           w_load_out;

    logic [MAX_WINDOW-1:0]          w_valid;
    logic [MAX_WINDOW-1:0]          w_old;
    logic signed [SAMPLE_WIDTH-1:0] w_value [MAX_WINDOW];
    logic [AW-1:0]                  w_age   [MAX_WINDOW];

    assign w_full    = (r_fill == r_win);
    assign w_rem_age = AW'(r_win - FW'(1));

    always_comb begin
        w_cmd       = '0;
        w_cmd.clear = i_cfg_we;
        w_cmd.del   = (r_state == S_DEL) && w_full;
        w_cmd.ins   = (r_state == S_INS);
    end

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
            logic                           w_lv;
            logic signed [SAMPLE_WIDTH-1:0] w_lval;
            logic [AW-1:0]                  w_lage;
            logic                           w_rv;
            logic signed [SAMPLE_WIDTH-1:0] w_rval;
            logic [AW-1:0]                  w_rage;

            if (g == 0) begin : g_left_edge
                assign w_lv   = 1'b0;
                assign w_lval = '0;
                assign w_lage = '0;
            end else begin : g_left
                assign w_lv   = w_valid[g-1];
                assign w_lval = w_value[g-1];
                assign w_lage = w_age[g-1];
            end

            if (g == MAX_WINDOW - 1) begin : g_right_edge
                assign w_rv   = 1'b0;
                assign w_rval = '0;
                assign w_rage = '0;
            end else begin : g_right
                assign w_rv   = w_valid[g+1];
                assign w_rval = w_value[g+1];
                assign w_rage = w_age[g+1];
            end

            swmf_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .AGE_WIDTH    (AW),
                .FIRST        (g == 0)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (w_cmd),
                .i_sample      (r_sample),
                .i_rem_value   (w_rem_value),
                .i_rem_age     (w_rem_age),
                .i_left_valid  (w_lv),
                .i_left_value  (w_lval),
                .i_left_age    (w_lage),
                .i_right_valid (w_rv),
                .i_right_value (w_rval),
                .i_right_age   (w_rage),
                .o_valid       (w_valid[g]),
                .o_value       (w_value[g]),
                .o_age         (w_age[g]),
                .o_old         (w_old[g])
            );
        end
    endgenerate

    // value of the oldest sample, picked by its one-hot age match
    always_comb begin
        w_rem_value = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            w_rem_value = w_rem_value | (w_old[k] ? w_value[k] : '0);
        end
    end

    // middle pair: equal indexes for an odd count
    assign w_lo_full   = (r_fill - FW'(1)) >> 1;
    assign w_hi_full   = r_fill >> 1;
    assign w_lo        = w_value[w_lo_full[AW-1:0]];
    assign w_hi        = w_value[w_hi_full[AW-1:0]];
    assign n_median_x2 = {w_lo[SAMPLE_WIDTH-1], w_lo} + {w_hi[SAMPLE_WIDTH-1], w_hi};

    assign w_cfg_ext  = 32'(i_cfg_data);
    assign w_load_out = (r_state == S_MED) && (!r_out_valid || i_ready);

    always_comb begin
        n_state       = r_state;
        n_win         = r_win;
        n_fill        = r_fill;
        n_out_valid   = r_out_valid;
        n_window_full = r_window_full;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DEL;
                end
            end
            S_DEL: begin
                n_state = S_INS;
            end
            S_INS: begin
                if (!w_full) begin
                    n_fill = r_fill + FW'(1);
                end
                n_state = S_MED;
            end
            S_MED: begin
                if (w_load_out) begin
                    n_out_valid   = 1'b1;
                    n_window_full = w_full;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_fill = '0;
            if (w_cfg_ext == 32'd0) begin
                n_win = FW'(1);
            end else if (w_cfg_ext > 32'(MAX_WINDOW)) begin
                n_win = FW'(MAX_WINDOW);
            end else begin
                n_win = FW'(w_cfg_ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_win         <= FW'(1);
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
            r_median_x2   <= '0;
            r_window_full <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_win         <= n_win;
            r_fill        <= n_fill;
            r_out_valid   <= n_out_valid;
            r_window_full <= n_window_full;
            if (w_load_out) begin
                r_median_x2 <= n_median_x2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_sample <= i_sample;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_median_x2   = r_median_x2;
    assign o_window_full = r_window_full;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_win)
        else $error("fill count beyond window size");

    a_cells_match_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(w_valid) == int'(r_fill)))
        else $error("occupied cells disagree with fill count");

    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_fill == '0) && (w_valid == '0))
        else $error("window not emptied by size write");

    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) && w_full |-> $onehot(w_old))
        else $error("oldest sample not unique in full window");

endmodule

// ===== rtl/core/swmf_cell.sv =====
module swmf_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int AGE_WIDTH    = 5,
    parameter bit FIRST        = 1'b0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  swmf_pkg::t_cell_cmd            i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_rem_value,
    input  logic        [AGE_WIDTH-1:0]    i_rem_age,
    input  logic                           i_left_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left_value,
    input  logic        [AGE_WIDTH-1:0]    i_left_age,
    input  logic                           i_right_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_value,
    input  logic        [AGE_WIDTH-1:0]    i_right_age,
    output logic                           o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic        [AGE_WIDTH-1:0]    o_age,
    output logic                           o_old
);
    import swmf_pkg::*;

    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic        [AGE_WIDTH-1:0]    r_age;
    logic                           w_shift;
    logic                           w_take_left;
    logic                           w_take_new;

    assign o_old = r_valid && (r_age == i_rem_age);

    // on delete, every cell at or above the removed one pulls from its right neighbor
    assign w_shift = r_valid && (o_old || (r_value > i_rem_value));

    // new sample goes in front of equal values, so equal values stay youngest first
    assign w_take_left = !FIRST && i_left_valid && (i_left_value >= i_sample);
    assign w_take_new  = !r_valid || (r_value >= i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            priority if (i_cmd.clear) begin
                r_valid <= 1'b0;
            end else if (i_cmd.del) begin
                if (w_shift) begin
                    r_valid <= i_right_valid;
                    r_value <= i_right_value;
                    r_age   <= i_right_age;
                end
            end else if (i_cmd.ins) begin
                r_valid <= r_valid || i_left_valid || FIRST;
                if (w_take_left) begin
                    r_value <= i_left_value;
                    r_age   <= i_left_age + AGE_WIDTH'(1);
                end else if (w_take_new) begin
                    r_value <= i_sample;
                    r_age   <= '0;
                end else begin
                    r_age   <= r_age + AGE_WIDTH'(1);
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_age   = r_age;

endmodule
